### rtl/core/assert_macros.svh
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define RBCC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/rbcc_pkg.sv
// Package: types and constants of the ray / box convex brush clipper.
`timescale 1ns / 1ps
package rbcc_pkg;

  localparam int BRUSH_COUNT = 4096;
  localparam int IDX_W       = $clog2(BRUSH_COUNT);
  localparam int BRUSH_W     = 12;
  localparam int CMD_W       = 3;
  localparam int Q_W         = 32;
  localparam int SURF_W      = 16;
  localparam int EPS_W       = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = 17'd2048;
  localparam logic signed [Q_W-1:0] ONE_Q = 32'sh0001_0000;
  localparam int EPOCH_W     = 8;
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int PROD_W      = 2 * Q_W;
  localparam int FRAC_W      = 16;
  localparam int DOT_W       = 50;
  localparam int ACC_W       = 54;
  localparam int DIV_ITER    = 31;
  localparam int SAT_SH      = DIV_ITER - FRAC_W;
  localparam int DCNT_W      = $clog2(DIV_ITER);
  localparam int MUL_STEPS   = 9;
  localparam int MSTEP_W     = 4;

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_DELTA  = 3'd1,
    CMD_BOX_LO = 3'd2,
    CMD_BOX_HI = 3'd3,
    CMD_SIDE   = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t                op;
    q_t                  vx;
    q_t                  vy;
    q_t                  vz;
    q_t                  offset;
    logic [SURF_W-1:0]   surf;
    logic [BRUSH_W-1:0]  brush;
    q_t                  start_t;
    logic                point;
    logic                last;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_VISIT, B_CHECK, B_MUL, B_SUM, B_NUM, B_DIV, B_END
  } back_state_t;

  typedef enum logic [1:0] {
    D_IDLE, D_CHECK, D_RUN, D_DONE
  } div_state_t;

endpackage

### rtl/core/ray_box_convex_brush_clip_top.sv
// Top level of the ray / swept box clipper against convex brush planes.
//
//  channel   | ports                                   | beat taken when
//  ----------+-----------------------------------------+-------------------------
//  input     | in_push in_full in_command ... in_last_side | in_push && !in_full
//  result    | out_pop out_empty out_trace_fraction ...    | out_pop && !out_empty
//  config    | cfg_wr_en cfg_wr_data (plane_epsilon)        | cfg_wr_en
//
// A four deep queue splits the front (accept, drop unknown opcodes) from the
// back end, which runs one beat at a time.
// Start, delta and box beats are handled directly by the back end; a side
// of a brush that is skipped, dead or already empty skips the multiplier.
// A live side uses the shared 32x32 multiplier for the three dot products,
// then the serial divider (one quotient bit per cycle), plus sums and bookkeeping.
// After reset the visited map (4096 entries) is swept with in_full held;
// the same sweep runs on every 255th start command when the epoch wraps.
// A finished result sits in an output register; the back end stalls only
// on a last side while that register is still full.
`timescale 1ns / 1ps
module ray_box_convex_brush_clip_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [rbcc_pkg::CMD_W-1:0]    in_command,
  input  rbcc_pkg::q_t                  in_vec_x,
  input  rbcc_pkg::q_t                  in_vec_y,
  input  rbcc_pkg::q_t                  in_vec_z,
  input  rbcc_pkg::q_t                  in_plane_offset,
  input  logic [rbcc_pkg::SURF_W-1:0]   in_surface_id,
  input  logic [rbcc_pkg::BRUSH_W-1:0]  in_brush_number,
  input  rbcc_pkg::q_t                  in_start_t,
  input  logic                          in_point_trace,
  input  logic                          in_last_side,
  input  logic                          out_pop,
  output logic                          out_empty,
  output rbcc_pkg::q_t                  out_trace_fraction,
  output rbcc_pkg::q_t                  out_hit_normal_x,
  output rbcc_pkg::q_t                  out_hit_normal_y,
  output rbcc_pkg::q_t                  out_hit_normal_z,
  output rbcc_pkg::q_t                  out_hit_plane_offset,
  output logic [rbcc_pkg::SURF_W-1:0]   out_hit_surface,
  output logic                          out_starts_solid,
  output logic                          out_all_solid,
  output logic [rbcc_pkg::BRUSH_W-1:0]  out_hit_brush,
  output logic                          out_brush_skipped,
  input  logic                          cfg_wr_en,
  input  logic [rbcc_pkg::EPS_W-1:0]    cfg_wr_data
);
  import rbcc_pkg::*;

  item_t      head;
  logic       head_valid;
  back_stat_t stat;

  // front: opcode filter and item queue
  rbcc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_vec_x        (in_vec_x),
    .in_vec_y        (in_vec_y),
    .in_vec_z        (in_vec_z),
    .in_plane_offset (in_plane_offset),
    .in_surface_id   (in_surface_id),
    .in_brush_number (in_brush_number),
    .in_start_t      (in_start_t),
    .in_point_trace  (in_point_trace),
    .in_last_side    (in_last_side),
    .stat            (stat),
    .head            (head),
    .head_valid      (head_valid)
  );

  // back: clipping math, trace record, visited map, result register
  rbcc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .head                 (head),
    .head_valid           (head_valid),
    .stat                 (stat),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_trace_fraction   (out_trace_fraction),
    .out_hit_normal_x     (out_hit_normal_x),
    .out_hit_normal_y     (out_hit_normal_y),
    .out_hit_normal_z     (out_hit_normal_z),
    .out_hit_plane_offset (out_hit_plane_offset),
    .out_hit_surface      (out_hit_surface),
    .out_starts_solid     (out_starts_solid),
    .out_all_solid        (out_all_solid),
    .out_hit_brush        (out_hit_brush),
    .out_brush_skipped    (out_brush_skipped)
  );

endmodule

### rtl/core/rbcc_front.sv
// Front end: command classification and the item queue to the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbcc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [rbcc_pkg::CMD_W-1:0]    in_command,
  input  rbcc_pkg::q_t                  in_vec_x,
  input  rbcc_pkg::q_t                  in_vec_y,
  input  rbcc_pkg::q_t                  in_vec_z,
  input  rbcc_pkg::q_t                  in_plane_offset,
  input  logic [rbcc_pkg::SURF_W-1:0]   in_surface_id,
  input  logic [rbcc_pkg::BRUSH_W-1:0]  in_brush_number,
  input  rbcc_pkg::q_t                  in_start_t,
  input  logic                          in_point_trace,
  input  logic                          in_last_side,
  input  rbcc_pkg::back_stat_t          stat,
  output rbcc_pkg::item_t               head,
  output logic                          head_valid
);
  import rbcc_pkg::*;

  item_t             q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              keep, accept, push;
  item_t             item;

  // unknown opcodes are taken and dropped
  always_comb begin
    unique case (in_command)
      CMD_START, CMD_DELTA, CMD_BOX_LO, CMD_BOX_HI, CMD_SIDE: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    item.op      = cmd_t'(in_command);
    item.vx      = in_vec_x;
    item.vy      = in_vec_y;
    item.vz      = in_vec_z;
    item.offset  = in_plane_offset;
    item.surf    = in_surface_id;
    item.brush   = in_brush_number;
    item.start_t = in_start_t;
    item.point   = in_point_trace;
    item.last    = in_last_side;
  end

  assign in_full    = (cnt_r == (QPTR_W+1)'(Q_DEPTH)) || stat.clearing;
  assign accept     = in_push && !in_full;
  assign push       = accept && keep;
  assign head_valid = (cnt_r != '0);
  assign head       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (stat.pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(stat.pop);
    end
  end

  `RBCC_NEVER(a_q_over, cnt_r > (QPTR_W+1)'(Q_DEPTH), "item queue overflow")
  `RBCC_NEVER(a_q_under, stat.pop && (cnt_r == '0), "pop from empty item queue")

endmodule

### rtl/core/rbcc_div.sv
// Serial divider: saturated Q16.16 crossing fraction -num / den.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbcc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rbcc_pkg::ACC_W-1:0]  num,
  input  logic signed [rbcc_pkg::DOT_W-1:0]  den,
  output logic                               done,
  output rbcc_pkg::q_t                       quot
);
  import rbcc_pkg::*;

  div_state_t           state_r, state_nxt;
  logic [ACC_W-1:0]     un_r;
  logic [DOT_W-1:0]     ud_r, rem_r;
  logic [DIV_ITER-1:0]  dvd_r, q_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic                 neg_r, zero_r;
  q_t                   quot_r;
  logic [DOT_W:0]       rem_s;
  logic                 ge, sat;

  assign rem_s = {rem_r, dvd_r[DIV_ITER-1]};
  assign ge    = rem_s >= {1'b0, ud_r};
  assign sat   = (DOT_W+FRAC_W)'(un_r) >= ((DOT_W+FRAC_W)'(ud_r) << SAT_SH);
  assign done  = (state_r == D_DONE);
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= D_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE:  if (start) state_nxt = D_CHECK;
      D_CHECK: state_nxt = (zero_r || sat) ? D_DONE : D_RUN;
      D_RUN:   if (cnt_r == DCNT_W'(DIV_ITER-1)) state_nxt = D_DONE;
      D_DONE:  state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          un_r   <= $unsigned(num < 0 ? -num : num);
          ud_r   <= $unsigned(den < 0 ? -den : den);
          neg_r  <= (num > 0) == (den > 0);
          zero_r <= (num == '0);
        end
      end
      D_CHECK: begin
        if (zero_r) begin
          quot_r <= '0;
        end else if (sat) begin
          quot_r <= neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        rem_r <= DOT_W'(un_r >> SAT_SH);
        dvd_r <= {un_r[SAT_SH-1:0], FRAC_W'(0)};
        q_r   <= '0;
        cnt_r <= '0;
      end
      D_RUN: begin
        rem_r <= ge ? DOT_W'(rem_s - {1'b0, ud_r}) : rem_s[DOT_W-1:0];
        q_r   <= {q_r[DIV_ITER-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_ITER-1)) begin
          quot_r <= neg_r ? -$signed({1'b0, q_r[DIV_ITER-2:0], ge})
                          :  $signed({1'b0, q_r[DIV_ITER-2:0], ge});
        end
      end
      default: ;
    endcase
  end

  `RBCC_NEVER(a_div_restart, start && (state_r != D_IDLE), "divider started while busy")

endmodule

### rtl/core/rbcc_back.sv
// Back end: trace state, dot product sequencer, visited map and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbcc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rbcc_pkg::EPS_W-1:0]    cfg_wr_data,
  input  rbcc_pkg::item_t               head,
  input  logic                          head_valid,
  output rbcc_pkg::back_stat_t          stat,
  input  logic                          out_pop,
  output logic                          out_empty,
  output rbcc_pkg::q_t                  out_trace_fraction,
  output rbcc_pkg::q_t                  out_hit_normal_x,
  output rbcc_pkg::q_t                  out_hit_normal_y,
  output rbcc_pkg::q_t                  out_hit_normal_z,
  output rbcc_pkg::q_t                  out_hit_plane_offset,
  output logic [rbcc_pkg::SURF_W-1:0]   out_hit_surface,
  output logic                          out_starts_solid,
  output logic                          out_all_solid,
  output logic [rbcc_pkg::BRUSH_W-1:0]  out_hit_brush,
  output logic                          out_brush_skipped
);
  import rbcc_pkg::*;

  back_state_t state_r, state_nxt;

  // visited map with epoch marks
  logic [EPOCH_W-1:0] vis_mem [BRUSH_COUNT];
  logic [EPOCH_W-1:0] vis_rd_r, epoch_r, vis_wdata;
  logic [IDX_W-1:0]   clr_cnt_r, vis_waddr;
  logic               vis_we, vis_hit;

  // trace setup
  logic [EPS_W-1:0] eps_r;
  q_t origin_r [3];
  q_t delta_r  [3];
  q_t lo_r     [3];
  q_t hi_r     [3];
  logic point_r;

  // record
  q_t best_r, rec_off_r;
  q_t rec_n_r [3];
  logic [SURF_W-1:0]  rec_surf_r;
  logic               rec_ss_r, rec_as_r;
  logic [BRUSH_W-1:0] rec_brush_r;

  // brush in progress
  logic active_r, dead_r, skip_r;
  logic [BRUSH_W-1:0] cur_brush_r;
  q_t enter_r, exit_r, ent_d_r;
  q_t ent_n_r [3];
  logic [SURF_W-1:0] ent_surf_r;

  // datapath
  item_t                     cur_r;
  logic [MSTEP_W-1:0]        mstep_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DOT_W-1:0]   acc_off_r, acc_vd_r, acc_pd_r, flr;
  logic signed [ACC_W-1:0]   sum_r, offs, num;
  q_t                        opa, opb, cx, cy, cz;
  logic                      div_start, div_done;
  q_t                        div_q;

  // brush end
  logic upd, out_free, pop, fire;
  q_t best_n, rec_off_n;
  q_t rec_n_n [3];
  logic [SURF_W-1:0]  rec_surf_n;
  logic               rec_ss_n, rec_as_n;
  logic [BRUSH_W-1:0] rec_brush_n;
  logic out_valid_r;

  assign vis_hit   = (vis_rd_r == epoch_r);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign fire      = (state_r == B_END) && cur_r.last && out_free;
  assign stat.pop      = pop;
  assign stat.clearing = (state_r == B_CLEAR);

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_rd_r <= vis_mem[head.brush[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    div_start = 1'b0;
    vis_we    = 1'b0;
    vis_waddr = clr_cnt_r;
    vis_wdata = '0;
    unique case (state_r)
      B_CLEAR: begin
        vis_we = 1'b1;
        if (clr_cnt_r == IDX_W'(BRUSH_COUNT-1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.op)
            CMD_START: if (epoch_r == '1) state_nxt = B_CLEAR;
            CMD_SIDE:  state_nxt = active_r ? B_CHECK : B_VISIT;
            default: ;
          endcase
        end
      end
      B_VISIT: begin
        state_nxt = B_CHECK;
        if (!vis_hit) begin
          vis_we    = 1'b1;
          vis_waddr = cur_brush_r[IDX_W-1:0];
          vis_wdata = epoch_r;
        end
      end
      B_CHECK: state_nxt = (skip_r || dead_r || (enter_r > exit_r)) ? B_END : B_MUL;
      B_MUL:   if (mstep_r == MSTEP_W'(MUL_STEPS)) state_nxt = B_SUM;
      B_SUM:   state_nxt = B_NUM;
      B_NUM: begin
        if (acc_vd_r == '0) begin
          state_nxt = B_END;
        end else begin
          div_start = 1'b1;
          state_nxt = B_DIV;
        end
      end
      B_DIV:   if (div_done) state_nxt = B_END;
      B_END:   if (!cur_r.last || out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // box corner picked by the normal's signs
  assign cx = (cur_r.vx < 0) ? hi_r[0] : lo_r[0];
  assign cy = (cur_r.vy < 0) ? hi_r[1] : lo_r[1];
  assign cz = (cur_r.vz < 0) ? hi_r[2] : lo_r[2];

  always_comb begin
    case (mstep_r)
      4'd0:    begin opa = cur_r.vx; opb = cx;          end
      4'd1:    begin opa = cur_r.vy; opb = cy;          end
      4'd2:    begin opa = cur_r.vz; opb = cz;          end
      4'd3:    begin opa = cur_r.vx; opb = delta_r[0];  end
      4'd4:    begin opa = cur_r.vy; opb = delta_r[1];  end
      4'd5:    begin opa = cur_r.vz; opb = delta_r[2];  end
      4'd6:    begin opa = cur_r.vx; opb = origin_r[0]; end
      4'd7:    begin opa = cur_r.vy; opb = origin_r[1]; end
      4'd8:    begin opa = cur_r.vz; opb = origin_r[2]; end
      default: begin opa = '0;       opb = '0;          end
    endcase
  end

  // floor to Q16.16 is an arithmetic shift
  assign flr  = DOT_W'($signed(prod_r[PROD_W-1:FRAC_W]));
  assign offs = point_r ? -ACC_W'(cur_r.offset)
                        : ACC_W'(acc_off_r) - ACC_W'(cur_r.offset);
  assign num  = (acc_vd_r < 0) ? sum_r - ACC_W'($signed({1'b0, eps_r}))
                               : sum_r + ACC_W'($signed({1'b0, eps_r}));

  rbcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (acc_vd_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    upd         = (enter_r < exit_r) && (enter_r < best_r);
    best_n      = best_r;
    rec_n_n     = rec_n_r;
    rec_off_n   = rec_off_r;
    rec_surf_n  = rec_surf_r;
    rec_ss_n    = rec_ss_r;
    rec_as_n    = rec_as_r;
    rec_brush_n = rec_brush_r;
    if (!skip_r) begin
      if (upd) begin
        best_n      = enter_r;
        rec_n_n     = ent_n_r;
        rec_off_n   = ent_d_r;
        rec_surf_n  = ent_surf_r;
        rec_ss_n    = enter_r < 0;
        rec_as_n    = (exit_r < 0) && (enter_r < 0);
        rec_brush_n = cur_brush_r;
      end else if (enter_r < 0) begin
        rec_ss_n    = 1'b1;
        if (exit_r < 0) rec_as_n = 1'b1;
        rec_brush_n = cur_brush_r;
      end
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    if (state_r == B_CHECK) begin
      mstep_r   <= '0;
      acc_off_r <= '0;
      acc_vd_r  <= '0;
      acc_pd_r  <= '0;
    end
    if (state_r == B_MUL) begin
      mstep_r <= mstep_r + 1'b1;
      if (mstep_r < MSTEP_W'(MUL_STEPS)) prod_r <= opa * opb;
      if (mstep_r >= 4'd1 && mstep_r <= 4'd3)      acc_off_r <= acc_off_r + flr;
      else if (mstep_r >= 4'd4 && mstep_r <= 4'd6) acc_vd_r  <= acc_vd_r + flr;
      else if (mstep_r >= 4'd7)                    acc_pd_r  <= acc_pd_r + flr;
    end
    if (state_r == B_SUM) sum_r <= ACC_W'(acc_pd_r) + offs;
    if (fire) begin
      out_trace_fraction   <= best_n;
      out_hit_normal_x     <= rec_n_n[0];
      out_hit_normal_y     <= rec_n_n[1];
      out_hit_normal_z     <= rec_n_n[2];
      out_hit_plane_offset <= rec_off_n;
      out_hit_surface      <= rec_surf_n;
      out_starts_solid     <= rec_ss_n;
      out_all_solid        <= rec_as_n;
      out_hit_brush        <= rec_brush_n;
      out_brush_skipped    <= skip_r;
    end
  end

  // trace and brush state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      eps_r       <= EPS_RESET;
      origin_r    <= '{default: '0};
      delta_r     <= '{default: '0};
      lo_r        <= '{default: '0};
      hi_r        <= '{default: '0};
      point_r     <= 1'b1;
      best_r      <= ONE_Q;
      rec_n_r     <= '{default: '0};
      rec_off_r   <= '0;
      rec_surf_r  <= '0;
      rec_ss_r    <= 1'b0;
      rec_as_r    <= 1'b0;
      rec_brush_r <= '0;
      active_r    <= 1'b0;
      dead_r      <= 1'b0;
      skip_r      <= 1'b0;
      cur_brush_r <= '0;
      enter_r     <= '0;
      exit_r      <= ONE_Q;
      ent_n_r     <= '{default: '0};
      ent_d_r     <= '0;
      ent_surf_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) eps_r <= cfg_wr_data;
      out_valid_r <= fire || (out_valid_r && !out_pop);
      unique case (state_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IDX_W'(BRUSH_COUNT-1)) epoch_r <= EPOCH_W'(1);
        end
        B_IDLE: begin
          if (pop) begin
            case (head.op)
              CMD_START: begin
                if (epoch_r != '1) epoch_r <= epoch_r + 1'b1;
                best_r      <= head.start_t;
                origin_r    <= '{head.vx, head.vy, head.vz};
                point_r     <= head.point;
                rec_n_r     <= '{default: '0};
                rec_off_r   <= '0;
                rec_surf_r  <= '0;
                rec_ss_r    <= 1'b0;
                rec_as_r    <= 1'b0;
                rec_brush_r <= '0;
                active_r    <= 1'b0;
                dead_r      <= 1'b0;
                skip_r      <= 1'b0;
                cur_brush_r <= '0;
                enter_r     <= '0;
                exit_r      <= ONE_Q;
                ent_n_r     <= '{default: '0};
                ent_d_r     <= '0;
                ent_surf_r  <= '0;
              end
              CMD_DELTA:  delta_r <= '{head.vx, head.vy, head.vz};
              CMD_BOX_LO: lo_r    <= '{head.vx, head.vy, head.vz};
              CMD_BOX_HI: hi_r    <= '{head.vx, head.vy, head.vz};
              CMD_SIDE: begin
                if (!active_r) begin
                  active_r    <= 1'b1;
                  dead_r      <= 1'b0;
                  skip_r      <= 1'b0;
                  cur_brush_r <= head.brush;
                  enter_r     <= '0;
                  exit_r      <= ONE_Q;
                  ent_n_r     <= '{default: '0};
                  ent_d_r     <= '0;
                  ent_surf_r  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        B_VISIT: skip_r <= vis_hit;
        B_NUM: begin
          if ((acc_vd_r == '0) && (sum_r > 0)) begin
            dead_r  <= 1'b1;
            enter_r <= exit_r + ONE_Q;
          end
        end
        B_DIV: begin
          if (div_done) begin
            if (acc_vd_r < 0) begin
              if (div_q > enter_r) begin
                enter_r    <= div_q;
                ent_n_r    <= '{cur_r.vx, cur_r.vy, cur_r.vz};
                ent_d_r    <= cur_r.offset;
                ent_surf_r <= cur_r.surf;
              end
            end else if (div_q < exit_r) begin
              exit_r <= div_q;
            end
          end
        end
        B_END: begin
          if (fire) begin
            best_r      <= best_n;
            rec_n_r     <= rec_n_n;
            rec_off_r   <= rec_off_n;
            rec_surf_r  <= rec_surf_n;
            rec_ss_r    <= rec_ss_n;
            rec_as_r    <= rec_as_n;
            rec_brush_r <= rec_brush_n;
            active_r    <= 1'b0;
            dead_r      <= 1'b0;
            skip_r      <= 1'b0;
            cur_brush_r <= '0;
            enter_r     <= '0;
            exit_r      <= ONE_Q;
            ent_n_r     <= '{default: '0};
            ent_d_r     <= '0;
            ent_surf_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `RBCC_ASSERT(a_out_hold, out_valid_r && !out_pop |=> out_valid_r, "pending result lost")
  `RBCC_NEVER(a_pop_busy, pop && (state_r != B_IDLE), "item taken while back end busy")
  `RBCC_NEVER(a_div_idle, div_done && (state_r != B_DIV), "divider result not awaited")

endmodule
